// File: hw/rtl/fad_pkg.sv
// Shared constants and types for the fault address decoder.
package fad_pkg;

  // Register file geometry.
  localparam int unsigned RegCount = 16;
  localparam int unsigned RegAw    = 4;
  localparam int unsigned DataW    = 32;

  // Register numbers with a fixed role.
  localparam logic [RegAw-1:0] RegSp = 4'd13;
  localparam logic [RegAw-1:0] RegPc = 4'd15;

  // Input operation codes.
  localparam logic OpWrite   = 1'b0;
  localparam logic OpCompute = 1'b1;

  // ARM format masks and match values.
  localparam logic [31:0] ArmSwpMask  = 32'h0FB0_0FF0;
  localparam logic [31:0] ArmSwpMatch = 32'h0100_0090;
  localparam logic [31:0] ArmLdrMask  = 32'h0C00_0000;
  localparam logic [31:0] ArmLdrMatch = 32'h0400_0000;
  localparam logic [31:0] ArmHwMask   = 32'h0E40_0F90;
  localparam logic [31:0] ArmHwrMatch = 32'h0000_0090;
  localparam logic [31:0] ArmHwiMatch = 32'h0040_0090;
  localparam logic [31:0] ArmLdmMask  = 32'h0E00_0000;
  localparam logic [31:0] ArmLdmMatch = 32'h0800_0000;

  // Shift field value that means an unshifted register offset.
  localparam logic [7:0] ShiftPlain = 8'h0B;

  // Thumb format masks and match values.
  localparam logic [15:0] ThPcMask    = 16'hF800;
  localparam logic [15:0] ThPcMatch   = 16'h4800;
  localparam logic [15:0] ThRegMask   = 16'hF200;
  localparam logic [15:0] ThRegMatchA = 16'h5000;
  localparam logic [15:0] ThRegMatchB = 16'h5200;
  localparam logic [15:0] ThImmMask   = 16'hE000;
  localparam logic [15:0] ThImmMatch  = 16'h6000;
  localparam logic [15:0] ThNibMask   = 16'hF000;
  localparam logic [15:0] ThHwMatch   = 16'h8000;
  localparam logic [15:0] ThSpMatch   = 16'h9000;
  localparam logic [15:0] ThPushMask  = 16'hF700;
  localparam logic [15:0] ThPushMatch = 16'hB500;
  localparam logic [15:0] ThLdmMatch  = 16'hC000;

  // Barrel shifter operation.
  typedef enum logic [1:0] {
    SHIFT_LSL = 2'd0,
    SHIFT_LSR = 2'd1,
    SHIFT_ASR = 2'd2,
    SHIFT_ROR = 2'd3
  } shift_kind_t;

endpackage

// File: hw/rtl/fad_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fad_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/fault_address_decoder.sv
// Top level of the data abort fault address decoder.
//
// The input channel (in_valid/in_stall) carries one word per item. A word with
// op low writes reg_value into register reg_index and gives no result. A word
// with op high decodes instruction (ARM, or Thumb when thumb is set, bits 15:0)
// and yields one output word with fault_address and recognized; encodings that
// are not loads or stores give address zero with recognized low.
// The register file sits in three copies of a 16-entry synchronous RAM, so
// base, index and shift-amount registers are read in the same cycle.
// A compute word is read from the RAM at the edge that accepts it; decode, shift
// and add then feed the output register, which presents the result. The read
// stage takes one word per cycle while the output is not stalled; the limit is
// the single stage between the RAM read and the output register.
// When the receiver stalls, the result holds in the output register, one more
// result waits in the read stage, and only then is in_stall raised.
// Reset clears the handshake state and marks every register as zero through a
// set of per-entry valid flags; there is no clearing pass.
module fault_address_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [3:0]  reg_index,
  input  logic [31:0] reg_value,
  input  logic [31:0] instruction,
  input  logic        thumb,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] fault_address,
  output logic        recognized
);

  import fad_pkg::*;

  logic                  in_acc;
  logic                  wr_en;
  logic                  rd_en;
  logic [RegAw-1:0]      addr_a;
  logic [RegAw-1:0]      addr_b;
  logic [RegAw-1:0]      addr_c;
  logic [RegAw-1:0]      th_base_addr;
  logic [15:0]           in_th;
  logic [RegCount-1:0]   vld;
  logic                  ok_a;
  logic                  ok_b;
  logic                  ok_c;
  logic [DataW-1:0]      ram_a;
  logic [DataW-1:0]      ram_b;
  logic [DataW-1:0]      ram_c;
  logic [DataW-1:0]      val_a;
  logic [DataW-1:0]      val_b;
  logic [DataW-1:0]      val_c;
  logic                  pipe_valid;
  logic [31:0]           ins_q;
  logic                  thumb_q;
  logic                  out_load;
  logic [15:0]           th;
  logic [4:0]            imm5;
  logic [7:0]            sh;
  logic [7:0]            shamt_r;
  logic [4:0]            amt;
  logic                  amt_zero;
  logic                  amt_big;
  shift_kind_t           kind;
  logic [DataW-1:0]      shifted;
  logic [2*DataW-1:0]    ror_wide;
  logic [DataW-1:0]      arm_off;
  logic [DataW-1:0]      arm_idx;
  logic [DataW-1:0]      th_addr;
  logic                  th_ok;
  logic [DataW-1:0]      arm_addr;
  logic                  arm_ok;
  logic [DataW-1:0]      addr_next;
  logic                  rec_next;

  // Handshake: the read stage advances when the output register can load.
  assign in_acc   = in_valid && !in_stall;
  assign out_load = pipe_valid && (!out_valid || !out_stall);
  assign in_stall = pipe_valid && !out_load;
  assign wr_en    = in_acc && (op == OpWrite);
  assign rd_en    = in_acc && (op == OpCompute);

  // Read addresses for the base, index and shift-amount registers.
  assign in_th = instruction[15:0];
  always_comb begin
    if ((in_th & ThPcMask) == ThPcMatch) begin
      th_base_addr = RegPc;
    end else if ((in_th & ThNibMask) == ThSpMatch ||
                 (in_th & ThPushMask) == ThPushMatch) begin
      th_base_addr = RegSp;
    end else if ((in_th & ThNibMask) == ThLdmMatch) begin
      th_base_addr = {1'b0, in_th[10:8]};
    end else begin
      th_base_addr = {1'b0, in_th[5:3]};
    end
  end

  assign addr_a = thumb ? th_base_addr : instruction[19:16];
  assign addr_b = thumb ? {1'b0, in_th[8:6]} : instruction[3:0];
  assign addr_c = instruction[11:8];

  // Register file copies, all written alike.
  fad_ram #(.WIDTH(DataW), .DEPTH(RegCount)) u_ram_a (
    .clk(clk), .we(wr_en), .waddr(reg_index), .wdata(reg_value),
    .re(rd_en), .raddr(addr_a), .rdata(ram_a)
  );
  fad_ram #(.WIDTH(DataW), .DEPTH(RegCount)) u_ram_b (
    .clk(clk), .we(wr_en), .waddr(reg_index), .wdata(reg_value),
    .re(rd_en), .raddr(addr_b), .rdata(ram_b)
  );
  fad_ram #(.WIDTH(DataW), .DEPTH(RegCount)) u_ram_c (
    .clk(clk), .we(wr_en), .waddr(reg_index), .wdata(reg_value),
    .re(rd_en), .raddr(addr_c), .rdata(ram_c)
  );

  // Per-entry written flags; an unwritten register reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[reg_index] <= 1'b1;
    end
  end

  // Read stage: flags and instruction captured alongside the RAM read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ok_a    <= vld[addr_a];
      ok_b    <= vld[addr_b];
      ok_c    <= vld[addr_c];
      ins_q   <= instruction;
      thumb_q <= thumb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (rd_en) begin
      pipe_valid <= 1'b1;
    end else if (out_load) begin
      pipe_valid <= 1'b0;
    end
  end

  assign val_a = ok_a ? ram_a : '0;
  assign val_b = ok_b ? ram_b : '0;
  assign val_c = ok_c ? ram_c : '0;

  // Thumb decode.
  assign th   = ins_q[15:0];
  assign imm5 = th[10:6];
  always_comb begin
    th_ok   = 1'b1;
    th_addr = '0;
    if ((th & ThPcMask) == ThPcMatch) begin
      th_addr = val_a + {22'd0, th[7:0], 2'b00};
    end else if ((th & ThRegMask) == ThRegMatchA || (th & ThRegMask) == ThRegMatchB) begin
      th_addr = val_a + val_b;
    end else if ((th & ThImmMask) == ThImmMatch) begin
      th_addr = th[12] ? val_a + {27'd0, imm5} : val_a + {25'd0, imm5, 2'b00};
    end else if ((th & ThNibMask) == ThHwMatch) begin
      th_addr = val_a + {26'd0, imm5, 1'b0};
    end else if ((th & ThNibMask) == ThSpMatch) begin
      th_addr = val_a + {22'd0, th[7:0], 2'b00};
    end else if ((th & ThPushMask) == ThPushMatch) begin
      th_addr = val_a;
    end else if ((th & ThNibMask) == ThLdmMatch) begin
      th_addr = val_a;
    end else begin
      th_ok = 1'b0;
    end
  end

  // Barrel shifter for the ARM scaled register offset.
  assign sh       = ins_q[11:4];
  assign shamt_r  = val_c[7:0];
  assign kind     = shift_kind_t'(sh[2:1]);
  assign amt      = sh[0] ? shamt_r[4:0] : sh[7:3];
  assign amt_zero = sh[0] ? (shamt_r == 8'd0) : (sh[7:3] == 5'd0);
  assign amt_big  = sh[0] && (shamt_r[7:5] != 3'd0);
  assign ror_wide = {val_b, val_b} >> amt;

  always_comb begin
    if (sh == ShiftPlain || amt_zero) begin
      shifted = val_b;
    end else begin
      case (kind)
        SHIFT_LSL: shifted = amt_big ? '0 : val_b << amt;
        SHIFT_LSR: shifted = amt_big ? '0 : val_b >> amt;
        SHIFT_ASR: shifted = amt_big ? {DataW{val_b[DataW-1]}}
                                     : DataW'($signed(val_b) >>> amt);
        SHIFT_ROR: shifted = ror_wide[DataW-1:0];
        default:   shifted = val_b;
      endcase
    end
  end

  // ARM decode; offset chosen per format, then pre/post index and up/down.
  always_comb begin
    arm_ok  = 1'b1;
    arm_off = '0;
    if ((ins_q & ArmSwpMask) == ArmSwpMatch) begin
      arm_off = '0;
    end else if ((ins_q & ArmLdrMask) == ArmLdrMatch) begin
      arm_off = ins_q[25] ? shifted : {20'd0, ins_q[11:0]};
    end else if ((ins_q & ArmHwMask) == ArmHwrMatch) begin
      arm_off = val_b;
    end else if ((ins_q & ArmHwMask) == ArmHwiMatch) begin
      arm_off = {24'd0, ins_q[11:8], ins_q[3:0]};
    end else if ((ins_q & ArmLdmMask) == ArmLdmMatch) begin
      arm_off = '0;
    end else begin
      arm_ok = 1'b0;
    end
  end

  assign arm_idx = ins_q[23] ? val_a + arm_off : val_a - arm_off;

  always_comb begin
    if ((ins_q & ArmSwpMask) == ArmSwpMatch ||
        (ins_q & ArmLdmMask) == ArmLdmMatch || !ins_q[24]) begin
      arm_addr = val_a;
    end else begin
      arm_addr = arm_idx;
    end
  end

  // Final selection; unmatched encodings give address zero.
  always_comb begin
    if (thumb_q) begin
      rec_next  = th_ok;
      addr_next = th_ok ? th_addr : '0;
    end else begin
      rec_next  = arm_ok;
      addr_next = arm_ok ? arm_addr : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      fault_address <= addr_next;
      recognized    <= rec_next;
    end
  end

  // A compute word always reaches the read stage on the next cycle.
  a_compute_enters: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> pipe_valid)
    else $error("compute word did not enter the read stage");

  // A register write never creates a result.
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !pipe_valid) |=> !pipe_valid)
    else $error("register write produced a pending result");

  // Unrecognized encodings report address zero.
  a_unrec_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !recognized) |-> (fault_address == '0))
    else $error("unrecognized encoding with nonzero address");

  // Reset leaves every register reading as zero.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (vld == '0))
    else $error("register flags not cleared by reset");

endmodule

// File: sim/tb_fault_address_decoder.sv
// Testbench for the fault address decoder: random and directed words, shadow predictor, checker.
module tb_fault_address_decoder;
  import fad_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomWords = 1725;
  localparam int unsigned DrainCycles = 8;

  // One input word as queued for the driver.
  typedef struct {
    logic        op;
    logic [3:0]  idx;
    logic [31:0] value;
    logic [31:0] ins;
    logic        thumb;
  } cpu_word_t;

  // Expected decoder output, with the instruction kept for messages.
  typedef struct {
    logic [31:0] addr;
    logic        hit;
    logic [31:0] ins;
    logic        thumb;
  } fault_result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = OpWrite;
  logic [3:0]  reg_index = '0;
  logic [31:0] reg_value = '0;
  logic [31:0] instruction = '0;
  logic        thumb = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] fault_address;
  logic        recognized;

  cpu_word_t     pending_words[$];
  fault_result_t pending_addrs[$];
  logic [31:0]   reg_shadow [RegCount];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   burst_left = 0;
  int unsigned   gap_left = 0;
  int unsigned   stall_span = 0;
  stall_style_t  stall_style = STALL_NONE;

  fault_address_decoder uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .reg_index(reg_index),
    .reg_value(reg_value),
    .instruction(instruction),
    .thumb(thumb),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .fault_address(fault_address),
    .recognized(recognized)
  );

  // Clock with a period of four units.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Offset of an ARM register-offset load/store, shifted as the shift field says.
  function automatic logic [31:0] barrel_offset(input logic [31:0] v, input logic [7:0] sh);
    shift_kind_t kind;
    logic [7:0]  amt;
    int unsigned rot;
    kind = shift_kind_t'(sh[2:1]);
    if (sh == ShiftPlain) return v;
    amt = sh[0] ? reg_shadow[sh[7:4]][7:0] : {3'b000, sh[7:3]};
    if (amt == 8'd0) return v;
    case (kind)
      SHIFT_LSL: return (amt >= 8'd32) ? 32'd0 : v << amt;
      SHIFT_LSR: return (amt >= 8'd32) ? 32'd0 : v >> amt;
      SHIFT_ASR: return (amt >= 8'd32) ? {32{v[31]}} : 32'($signed(v) >>> amt);
      default: begin
        rot = amt[4:0];
        if (rot == 0) return v;
        return (v >> rot) | (v << (32 - rot));
      end
    endcase
  endfunction

  // Pre-indexed words add or subtract the offset; post-indexed words use the base.
  function automatic logic [31:0] index_base(input logic [31:0] ins, input logic [31:0] base,
                                             input logic [31:0] off);
    if (!ins[24]) return base;
    return ins[23] ? base + off : base - off;
  endfunction

  // Data access address that a faulting instruction implies under the shadow registers.
  function automatic fault_result_t predict_fault(input logic [31:0] ins, input logic thb);
    fault_result_t res;
    logic [15:0]   t;
    logic [31:0]   rb;
    logic [31:0]   rn;
    logic [31:0]   rm;
    logic [4:0]    imm5;
    res.ins   = ins;
    res.thumb = thb;
    res.hit   = 1'b1;
    res.addr  = '0;
    t    = ins[15:0];
    rb   = reg_shadow[{1'b0, t[5:3]}];
    imm5 = t[10:6];
    rn   = reg_shadow[ins[19:16]];
    rm   = reg_shadow[ins[3:0]];
    if (thb) begin
      if ((t & ThPcMask) == ThPcMatch)
        res.addr = reg_shadow[RegPc] + {22'b0, t[7:0], 2'b00};
      else if ((t & ThRegMask) == ThRegMatchA || (t & ThRegMask) == ThRegMatchB)
        res.addr = rb + reg_shadow[{1'b0, t[8:6]}];
      else if ((t & ThImmMask) == ThImmMatch)
        res.addr = rb + (t[12] ? {27'b0, imm5} : {25'b0, imm5, 2'b00});
      else if ((t & ThNibMask) == ThHwMatch)
        res.addr = rb + {26'b0, imm5, 1'b0};
      else if ((t & ThNibMask) == ThSpMatch)
        res.addr = reg_shadow[RegSp] + {22'b0, t[7:0], 2'b00};
      else if ((t & ThPushMask) == ThPushMatch)
        res.addr = reg_shadow[RegSp];
      else if ((t & ThNibMask) == ThLdmMatch)
        res.addr = reg_shadow[{1'b0, t[10:8]}];
      else
        res.hit = 1'b0;
    end else begin
      if ((ins & ArmSwpMask) == ArmSwpMatch)
        res.addr = rn;
      else if ((ins & ArmLdrMask) == ArmLdrMatch)
        res.addr = index_base(ins, rn,
                              ins[25] ? barrel_offset(rm, ins[11:4]) : {20'b0, ins[11:0]});
      else if ((ins & ArmHwMask) == ArmHwrMatch)
        res.addr = index_base(ins, rn, rm);
      else if ((ins & ArmHwMask) == ArmHwiMatch)
        res.addr = index_base(ins, rn, {24'b0, ins[11:8], ins[3:0]});
      else if ((ins & ArmLdmMask) == ArmLdmMatch)
        res.addr = rn;
      else
        res.hit = 1'b0;
    end
    if (!res.hit) res.addr = '0;
    return res;
  endfunction

  // Random word forced into one encoding class.
  function automatic logic [31:0] fit_format(input logic [31:0] mask, input logic [31:0] match);
    return ($urandom & ~mask) | match;
  endfunction

  // Random Thumb halfword forced into one encoding class.
  function automatic logic [15:0] fit_thumb(input logic [15:0] mask, input logic [15:0] match);
    return (16'($urandom) & ~mask) | match;
  endfunction

  // Register contents biased toward shift amounts and sign boundaries.
  function automatic logic [31:0] pick_reg_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return {$urandom_range(0, 1) ? $urandom : 32'd0} & 32'hFFFF_FF00
                      | 32'($urandom_range(0, 40));
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h8000_0000;
      5:       return 32'h7FFF_FFFF;
      6:       return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_write(input logic [3:0] idx, input logic [31:0] value);
    cpu_word_t w;
    w.op    = OpWrite;
    w.idx   = idx;
    w.value = value;
    w.ins   = $urandom;
    w.thumb = 1'($urandom_range(0, 1));
    pending_words.push_back(w);
  endtask

  task automatic queue_compute(input logic [31:0] ins, input logic thb);
    cpu_word_t w;
    w.op    = OpCompute;
    w.idx   = 4'($urandom_range(0, 15));
    w.value = $urandom;
    w.ins   = ins;
    w.thumb = thb;
    pending_words.push_back(w);
  endtask

  // Random compute word, mostly well-formed loads and stores.
  task automatic queue_random_compute();
    logic [31:0] ins;
    if ($urandom_range(0, 9) < 4) begin
      ins = $urandom;
      case ($urandom_range(0, 8))
        0: ins[15:0] = fit_thumb(ThPcMask, ThPcMatch);
        1: ins[15:0] = fit_thumb(ThRegMask, ThRegMatchA);
        2: ins[15:0] = fit_thumb(ThRegMask, ThRegMatchB);
        3: ins[15:0] = fit_thumb(ThImmMask, ThImmMatch);
        4: ins[15:0] = fit_thumb(ThNibMask, ThHwMatch);
        5: ins[15:0] = fit_thumb(ThNibMask, ThSpMatch);
        6: ins[15:0] = fit_thumb(ThPushMask, ThPushMatch);
        7: ins[15:0] = fit_thumb(ThNibMask, ThLdmMatch);
        default: ins = $urandom;
      endcase
      queue_compute(ins, 1'b1);
    end else begin
      case ($urandom_range(0, 7))
        0: ins = fit_format(ArmSwpMask, ArmSwpMatch);
        1: ins = fit_format(ArmLdrMask | 32'h0200_0000, ArmLdrMatch);
        2, 3: begin
          ins = fit_format(ArmLdrMask | 32'h0200_0000, ArmLdrMatch | 32'h0200_0000);
          if ($urandom_range(0, 7) == 0) ins[11:4] = ShiftPlain;
        end
        4: ins = fit_format(ArmHwMask, ArmHwrMatch);
        5: ins = fit_format(ArmHwMask, ArmHwiMatch);
        6: ins = fit_format(ArmLdmMask, ArmLdmMatch);
        default: ins = $urandom;
      endcase
      queue_compute(ins, 1'b0);
    end
  endtask

  // Stimulus, reset and end of run.
  initial begin
    for (int i = 0; i < RegCount; i++) reg_shadow[i] = '0;

    // Directed words: field extremes, each format and the shifter corner cases.
    queue_write(4'd1, 32'h8000_0001);
    queue_write(4'd2, 32'h0000_0020);
    queue_write(RegPc, 32'hFFFF_FFFC);
    queue_write(RegSp, 32'h0000_1000);
    queue_write(4'd4, 32'hFFFF_FFFF);
    queue_compute(32'hE101_0092, 1'b0);
    queue_compute(32'hE591_0FFF, 1'b0);
    queue_compute(32'hE511_0FFF, 1'b0);
    queue_compute(32'hE491_0FFF, 1'b0);
    queue_compute(32'hE791_00B1, 1'b0);
    queue_compute(32'hE791_0251, 1'b0);
    queue_compute(32'hE791_0061, 1'b0);
    queue_compute(32'hE791_0F81, 1'b0);
    queue_compute(32'hE111_00B4, 1'b0);
    queue_compute(32'hE1D1_00BF, 1'b0);
    queue_compute(32'hE891_FFFF, 1'b0);
    queue_compute(32'hE081_0002, 1'b0);
    queue_compute(32'hFFFF_48FF, 1'b1);
    queue_compute(32'h0000_5088, 1'b1);
    queue_compute(32'h0000_6FC8, 1'b1);
    queue_compute(32'h0000_7FC8, 1'b1);
    queue_compute(32'h0000_8FC8, 1'b1);
    queue_compute(32'h0000_9FFF, 1'b1);
    queue_compute(32'h0000_BDFF, 1'b1);
    queue_compute(32'h0000_C9FF, 1'b1);
    queue_compute(32'h0000_0000, 1'b1);

    // Random words: register updates mixed with faulting instructions.
    for (int i = 0; i < RandomWords; i++) begin
      if ($urandom_range(0, 9) < 3) queue_write(4'($urandom_range(0, 15)), pick_reg_value());
      else queue_random_compute();
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || in_valid || pending_addrs.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0)
      $display("tb_fault_address_decoder passed");
    else
      $display("tb_fault_address_decoder failed");
    $finish;
  end

  // Driver: sends words in bursts and predicts each word it sees accepted.
  always @(posedge clk) begin : drive_words
    cpu_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (op == OpWrite) reg_shadow[reg_index] = reg_value;
        else pending_addrs.push_back(predict_fault(instruction, thumb));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 || pending_words.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          w = pending_words.pop_front();
          op          <= w.op;
          reg_index   <= w.idx;
          reg_value   <= w.value;
          instruction <= w.ins;
          thumb       <= w.thumb;
          in_valid    <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Monitor: checks each accepted result and varies the output stall.
  always @(posedge clk) begin : check_results
    fault_result_t want;
    logic          next_stall;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_addrs.size() == 0) begin
          report_mismatch($sformatf("unexpected result address %h recognized %b",
                                    fault_address, recognized));
        end else begin
          want = pending_addrs.pop_front();
          if (fault_address !== want.addr)
            report_mismatch($sformatf("fault_address %h, want %h (instruction %h thumb %b)",
                                      fault_address, want.addr, want.ins, want.thumb));
          if (recognized !== want.hit)
            report_mismatch($sformatf("recognized %b, want %b (instruction %h thumb %b)",
                                      recognized, want.hit, want.ins, want.thumb));
        end
      end

      // The stall style is redrawn at random whenever its span runs out.
      if (stall_span == 0) begin
        stall_style = stall_style_t'($urandom_range(0, 3));
        stall_span  = $urandom_range(16, 200);
      end
      stall_span--;
      case (stall_style)
        STALL_NONE:  next_stall = 1'b0;
        STALL_LIGHT: next_stall = ($urandom_range(0, 3) == 0);
        STALL_HEAVY: next_stall = ($urandom_range(0, 3) != 0);
        default:     next_stall = (cycle_count % 3 == 0);
      endcase
      out_stall <= next_stall;
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_fault_address_decoder failed");
      $finish;
    end
  end

endmodule

// File: filelist.f
hw/rtl/fad_pkg.sv
hw/rtl/fad_ram.sv
hw/rtl/fault_address_decoder.sv
sim/tb_fault_address_decoder.sv
